// ===== hdl/ddnc_pkg.sv =====
// Package for the date / day-count converter: payload types, calendar
// constants, the constant month tables and the year-start function.
// No dependencies.
`timescale 1ns / 1ps

package ddnc_pkg;

  // Calendar constants
  localparam logic [11:0] BASE_YEAR    = 12'd2000;
  localparam logic [11:0] LAST_YEAR    = 12'd2099;
  localparam logic [6:0]  MAX_YEAR_OFF = 7'd99;
  localparam logic [3:0]  LAST_MONTH   = 4'd12;
  localparam logic [3:0]  FEBRUARY     = 4'd2;
  localparam logic [15:0] DAYS_YEAR    = 16'd365;

  // Days before each month, common and leap years (index 12 = year length)
  localparam logic [8:0] DBM_NORM [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };
  localparam logic [8:0] DBM_LEAP [13] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
  };

  // Request word
  typedef struct packed {
    logic        kind;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] day_count;
  } req_t;

  // Response word
  typedef struct packed {
    logic [15:0] days_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic        out_of_range;
  } rsp_t;

  // Days before a month, picked from the leap or common table
  function automatic logic [8:0] days_before(input logic [3:0] idx, input logic leap);
    logic [8:0] val;
    val = leap ? DBM_LEAP[idx] : DBM_NORM[idx];
    return val;
  endfunction

  // First day count of year offset i (used with constant arguments only)
  function automatic logic [15:0] year_start(input int i);
    logic [15:0] val;
    val = 16'(i * 365) + 16'((i + 3) >> 2);
    return val;
  endfunction

endpackage

// ===== hdl/ddnc_req_if.sv =====
// Request channel of the date / day-count converter: valid, ready and the
// request fields. Depends on nothing.
`timescale 1ns / 1ps

interface ddnc_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [15:0] day_count;

  modport source (output valid, kind, year, month, day, day_count, input ready);
  modport sink   (input valid, kind, year, month, day, day_count, output ready);
endinterface

// ===== hdl/ddnc_rsp_if.sv =====
// Response channel of the date / day-count converter: valid, ready and the
// result fields. Depends on nothing.
`timescale 1ns / 1ps

interface ddnc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] days_out;
  logic [11:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic        out_of_range;

  modport source (output valid, days_out, year_out, month_out, day_out, out_of_range,
                  input ready);
  modport sink   (input valid, days_out, year_out, month_out, day_out, out_of_range,
                  output ready);
endinterface

// ===== hdl/ddnc_core.sv =====
// Combinational conversion between a date and a day count since 2000-01-01.
// Depends on ddnc_pkg (types, calendar tables).
`timescale 1ns / 1ps

module ddnc_core #(
  parameter int YEAR_SPAN = 20
) (
  input  ddnc_pkg::req_t req_i,
  output ddnc_pkg::rsp_t rsp_o
);

  // ---------------- date -> count ----------------
  logic [6:0]  off;
  logic [3:0]  mon_c;
  logic [4:0]  day_c;
  logic [8:0]  dbm0;
  logic        leap0;
  logic [15:0] count;

  // Saturate year and month to their legal ranges; a zero day becomes one
  always_comb begin
    if (req_i.year < ddnc_pkg::BASE_YEAR) begin
      off = 7'd0;
    end else if (req_i.year > ddnc_pkg::LAST_YEAR) begin
      off = ddnc_pkg::MAX_YEAR_OFF;
    end else begin
      off = 7'(req_i.year - ddnc_pkg::BASE_YEAR);
    end
    if (req_i.month == 4'd0) begin
      mon_c = 4'd1;
    end else if (req_i.month > ddnc_pkg::LAST_MONTH) begin
      mon_c = ddnc_pkg::LAST_MONTH;
    end else begin
      mon_c = req_i.month;
    end
    day_c = (req_i.day == 5'd0) ? 5'd1 : req_i.day;
  end

  assign leap0 = (off[1:0] == 2'd0);
  assign dbm0  = ddnc_pkg::days_before(mon_c - 4'd1, 1'b0);

  // 365 per year + month table + day - 1 + leap days before this year,
  // + one more past February of a leap year
  assign count = 16'(off) * ddnc_pkg::DAYS_YEAR
               + 16'(dbm0)
               + 16'(day_c - 5'd1)
               + 16'(7'(off + 7'd3) >> 2)
               + 16'(leap0 && (mon_c > ddnc_pkg::FEBRUARY));

  // ---------------- count -> date ----------------
  logic [YEAR_SPAN:0] ge;
  logic [6:0]  yoff;
  logic [15:0] ystart;
  logic        leap1;
  logic [8:0]  doy;
  logic [3:0]  mon1;
  logic [8:0]  mbase;
  logic        in_span;

  // Thermometer of year-start compares against constant boundaries
  for (genvar g = 0; g <= YEAR_SPAN; g++) begin : g_ystart
    assign ge[g] = (req_i.day_count >= ddnc_pkg::year_start(g));
  end

  assign in_span = !ge[YEAR_SPAN];

  // Pick the year whose interval holds the count (one-hot AND-OR select)
  always_comb begin
    yoff   = 7'd0;
    ystart = 16'd0;
    for (int i = 0; i < YEAR_SPAN; i++) begin
      if (ge[i] && !ge[i+1]) begin
        yoff   = yoff | 7'(i);
        ystart = ystart | ddnc_pkg::year_start(i);
      end
    end
  end

  assign leap1 = (yoff[1:0] == 2'd0);
  assign doy   = 9'(req_i.day_count - ystart) + 9'd1;

  // Month search over the day of year, same one-hot select
  always_comb begin
    mon1  = 4'd0;
    mbase = 9'd0;
    for (int k = 0; k < 12; k++) begin
      if ((doy > ddnc_pkg::days_before(4'(k), leap1)) &&
          !(doy > ddnc_pkg::days_before(4'(k + 1), leap1))) begin
        mon1  = mon1 | 4'(k + 1);
        mbase = mbase | ddnc_pkg::days_before(4'(k), leap1);
      end
    end
  end

  // ---------------- result word ----------------
  always_comb begin
    rsp_o.days_out     = 16'd0;
    rsp_o.year_out     = ddnc_pkg::BASE_YEAR;
    rsp_o.month_out    = 4'd1;
    rsp_o.day_out      = 5'd1;
    rsp_o.out_of_range = 1'b0;
    if (!req_i.kind) begin
      rsp_o.days_out = count;
    end else if (in_span) begin
      rsp_o.year_out  = ddnc_pkg::BASE_YEAR + 12'(yoff);
      rsp_o.month_out = mon1;
      rsp_o.day_out   = 5'(doy - mbase);
    end else begin
      rsp_o.out_of_range = 1'b1;
    end
  end

endmodule

// ===== hdl/date_day_number_converter.sv =====
// Top level of the date / day-count converter: input register, conversion
// logic, output register. Depends on ddnc_pkg, ddnc_req_if, ddnc_rsp_if,
// ddnc_core.
//
// Usage:
//   req_i carries a request word: kind 0 turns year/month/day into the day
//   count since 2000-01-01, kind 1 turns day_count into year/month/day.
//   rsp_o returns exactly one result word per request, in order.
//   Path: a word accepted is captured in the input register; its result
//   is loaded into the output register once that register is empty or
//   draining, and is shown on rsp_o from then on (one register hop each).
//   Throughput: one word per cycle while rsp_o.ready is high; the conversion
//   is a single pass of constant-table compares and adds between the two
//   registers. Stall: when rsp_o.ready is low the output register holds
//   its word; the input register takes a word only while it is empty, and
//   req_i.ready stays low while it is full until the output moves.
//   Reset (rst_ni low, asynchronous) empties both registers; nothing is lost
//   or replayed afterwards. Counts at or past YEAR_SPAN years give
//   2000-01-01 with out_of_range set.
`timescale 1ns / 1ps

module date_day_number_converter #(
  parameter int YEAR_SPAN = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ddnc_req_if.sink       req_i,
  ddnc_rsp_if.source     rsp_o
);

  logic           in_vld_q;
  ddnc_pkg::req_t in_q;
  logic           out_vld_q;
  ddnc_pkg::rsp_t out_q;
  ddnc_pkg::rsp_t conv;
  logic           out_ready;
  logic           in_ready;

  // Handshake: each register takes a word when it is empty or draining
  assign out_ready   = !out_vld_q || rsp_o.ready;
  assign in_ready    = !in_vld_q || out_ready;
  assign req_i.ready = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      in_q.kind      <= req_i.kind;
      in_q.year      <= req_i.year;
      in_q.month     <= req_i.month;
      in_q.day       <= req_i.day;
      in_q.day_count <= req_i.day_count;
    end
  end

  // Conversion
  ddnc_core #(
    .YEAR_SPAN(YEAR_SPAN)
  ) u_core (
    .req_i(in_q),
    .rsp_o(conv)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_vld_q) begin
      out_q <= conv;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.days_out     = out_q.days_out;
  assign rsp_o.year_out     = out_q.year_out;
  assign rsp_o.month_out    = out_q.month_out;
  assign rsp_o.day_out      = out_q.day_out;
  assign rsp_o.out_of_range = out_q.out_of_range;

`ifndef NO_ASSERTIONS
  // A word in the input register is never dropped while the output is blocked
  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_ready) |=> in_vld_q)
    else $error("input word dropped during stall");

  // Out-of-range results carry the fixed date and a zero count
  a_oor_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.out_of_range) |->
      (out_q.year_out == ddnc_pkg::BASE_YEAR) && (out_q.month_out == 4'd1) &&
      (out_q.day_out == 5'd1) && (out_q.days_out == 16'd0))
    else $error("out-of-range result not 2000-01-01");

  // Every shown result has a legal month and day
  a_legal_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.month_out != 4'd0) && (out_q.month_out <= 4'd12) &&
      (out_q.day_out != 5'd0) && (out_q.year_out >= ddnc_pkg::BASE_YEAR))
    else $error("illegal date in result");
`endif

endmodule
